// File: hdl/wtc_pkg.sv
// ---------------------------------------------------------------------------
// wtc_pkg
// Shared types, constants and character tests for the token classifier.
// ---------------------------------------------------------------------------
package wtc_pkg;

	typedef enum logic [2:0] {
		CLS_KEYWORD  = 3'd0,
		CLS_OPERATOR = 3'd1,
		CLS_NUMBER   = 3'd2,
		CLS_IDENT    = 3'd3,
		CLS_PUNCT    = 3'd4
	} wtc_class_t;

	localparam int CLASS_W    = 3;
	localparam int KWI_W      = 4;
	localparam int CHAR_W     = 8;
	localparam int HEAD_DEPTH = 9;
	localparam int KW_COUNT   = 15;
	localparam int KW_MAX_LEN = 8;

	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

	// Keyword spellings, right-aligned: the first character sits in the
	// highest used byte.
	localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
		64'("int"), 64'("float"), 64'("double"), 64'("char"), 64'("return"),
		64'("if"), 64'("else"), 64'("while"), 64'("for"), 64'("break"),
		64'("continue"), 64'("class"), 64'("public"), 64'("private"),
		64'("void")
	};

	localparam logic [KWI_W-1:0] KW_LEN [KW_COUNT] = '{
		4'd3, 4'd5, 4'd6, 4'd4, 4'd6, 4'd2, 4'd4, 4'd5,
		4'd3, 4'd5, 4'd8, 4'd5, 4'd6, 4'd7, 4'd4
	};

	typedef struct packed {
		wtc_class_t        cls;
		logic [KWI_W-1:0]  kwi;
		logic              has_punct;
		logic [CHAR_W-1:0] punct;
	} wtc_result_t;

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return c >= 8'd48 && c <= 8'd57;
	endfunction

	function automatic logic is_punct(input logic [CHAR_W-1:0] c);
		return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
			(c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
	endfunction

	function automatic logic is_set_punct(input logic [CHAR_W-1:0] c);
		return c == 8'h3B || c == 8'h2C || c == 8'h28 || c == 8'h29 ||
			c == 8'h7B || c == 8'h7D || c == 8'h5B || c == 8'h5D;
	endfunction

	function automatic logic is_operator(input logic [CHAR_W-1:0] c);
		return c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F || c == 8'h3D;
	endfunction

endpackage

// File: hdl/whitespace_token_classifier.sv
// ---------------------------------------------------------------------------
// whitespace_token_classifier
// Splits a byte stream into whitespace-separated tokens and classifies them.
// ---------------------------------------------------------------------------
// Text bytes enter on the s_ channel, one item per byte; s_tuser set marks a
// flush item that ends the final token. Results leave on the m_ channel, and
// m_tlast marks the final result caused by one input item.
// An input item is registered; an item that ends a token then loads the
// classified token into the result register. The block takes one byte per
// cycle while the receiver is ready. An item that ends a token with a peeled
// byte of the set ; , ( ) [ ] { } gives two results, on consecutive cycles
// while the receiver is ready; the next token needs at least one byte before
// it can end, so this never slows the input while the receiver is ready.
// When the receiver stalls, the result register holds and the input stalls
// only once an item that ends a token waits behind it.
// Reset empties both registers, drops any pending token and sets the line
// count to one.
// ---------------------------------------------------------------------------
module whitespace_token_classifier #(
	parameter int LINE_COUNT_WIDTH = 16,
	parameter int LENGTH_WIDTH     = 8,
	localparam int DATA_W = ((wtc_pkg::CLASS_W + wtc_pkg::KWI_W + LENGTH_WIDTH +
		wtc_pkg::CHAR_W + LINE_COUNT_WIDTH + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,  // text_byte
	input  logic              s_tuser,  // end_of_text
	output logic              m_tvalid,
	input  logic              m_tready,
	// token_class, keyword_index, word_length, punct_char, line_number
	output logic [DATA_W-1:0] m_tdata,
	output logic              m_tlast
);

	localparam logic [LENGTH_WIDTH-1:0]     LEN_MAX  = '1;
	localparam logic [LINE_COUNT_WIDTH-1:0] LINE_MAX = '1;

	logic                        in_valid_s1;
	logic [wtc_pkg::CHAR_W-1:0]  in_byte_s1;
	logic                        in_eot_s1;

	logic [wtc_pkg::CHAR_W-1:0]  head_q [wtc_pkg::HEAD_DEPTH];
	logic [LENGTH_WIDTH-1:0]     token_len_q;
	logic                        all_digits_q;
	logic [wtc_pkg::CHAR_W-1:0]  last_q;
	logic [LINE_COUNT_WIDTH-1:0] line_q;

	logic                        ends;
	logic                        produces;
	logic                        advance;
	logic                        out_free;
	wtc_pkg::wtc_result_t        res;
	logic [LENGTH_WIDTH-1:0]     word_len;

	assign ends     = in_eot_s1 || wtc_pkg::is_space(in_byte_s1);
	assign produces = ends && (token_len_q != '0);
	assign advance  = in_valid_s1 && (!produces || out_free);
	assign s_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_byte_s1 <= s_tdata;
			in_eot_s1  <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_len_q  <= '0;
			all_digits_q <= 1'b1;
			last_q       <= '0;
			line_q       <= LINE_COUNT_WIDTH'(1);
		end else if (advance) begin
			if (ends) begin
				token_len_q  <= '0;
				all_digits_q <= 1'b1;
				last_q       <= '0;
				if (!in_eot_s1 && in_byte_s1 == wtc_pkg::CH_NEWLINE &&
						line_q != LINE_MAX) begin
					line_q <= line_q + LINE_COUNT_WIDTH'(1);
				end
			end else begin
				if (token_len_q != '0 && !wtc_pkg::is_digit(last_q)) begin
					all_digits_q <= 1'b0;
				end
				last_q <= in_byte_s1;
				if (token_len_q != LEN_MAX) begin
					token_len_q <= token_len_q + LENGTH_WIDTH'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && !ends && token_len_q < LENGTH_WIDTH'(wtc_pkg::HEAD_DEPTH)) begin
			head_q[token_len_q[3:0]] <= in_byte_s1;
		end
	end

	wtc_classify #(
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_classify (
		.head       (head_q),
		.token_len  (token_len_q),
		.all_digits (all_digits_q),
		.last_char  (last_q),
		.res        (res),
		.word_len   (word_len)
	);

	wtc_result_reg #(
		.LINE_COUNT_WIDTH(LINE_COUNT_WIDTH),
		.LENGTH_WIDTH    (LENGTH_WIDTH),
		.DATA_W          (DATA_W)
	) u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && produces),
		.res      (res),
		.word_len (word_len),
		.line     (line_q),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// File: hdl/wtc_classify.sv
// ---------------------------------------------------------------------------
// wtc_classify
// Classifies the pending token from its stored head bytes and status.
// ---------------------------------------------------------------------------
module wtc_classify #(
	parameter int LENGTH_WIDTH = 8
) (
	input  logic [wtc_pkg::CHAR_W-1:0] head [wtc_pkg::HEAD_DEPTH],
	input  logic [LENGTH_WIDTH-1:0]    token_len,
	input  logic                       all_digits,
	input  logic [wtc_pkg::CHAR_W-1:0] last_char,
	output wtc_pkg::wtc_result_t       res,
	output logic [LENGTH_WIDTH-1:0]    word_len
);

	localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

	logic peel;
	logic digits;
	logic short_word;

	assign peel = (token_len > LENGTH_WIDTH'(1)) && wtc_pkg::is_punct(last_char);
	assign word_len = !peel ? token_len :
		(token_len == LEN_MAX) ? LEN_MAX : token_len - LENGTH_WIDTH'(1);
	assign digits = all_digits && (peel || wtc_pkg::is_digit(last_char));
	assign short_word = (token_len != LEN_MAX) &&
		(word_len <= LENGTH_WIDTH'(wtc_pkg::KW_MAX_LEN));

	always_comb begin
		logic found;
		logic match;
		found = 1'b0;
		res.cls = digits ? wtc_pkg::CLS_NUMBER : wtc_pkg::CLS_IDENT;
		res.kwi = '0;
		for (int i = 0; i < wtc_pkg::KW_COUNT; i++) begin
			match = short_word && (word_len == LENGTH_WIDTH'(wtc_pkg::KW_LEN[i]));
			for (int k = 0; k < wtc_pkg::KW_MAX_LEN; k++) begin
				if (k < int'(wtc_pkg::KW_LEN[i]) && head[k] !=
						wtc_pkg::KW_TEXT[i][8*(int'(wtc_pkg::KW_LEN[i])-1-k) +: 8]) begin
					match = 1'b0;
				end
			end
			if (match && !found) begin
				found = 1'b1;
				res.cls = wtc_pkg::CLS_KEYWORD;
				res.kwi = wtc_pkg::KWI_W'(i);
			end
		end
		if (!found && short_word && word_len == LENGTH_WIDTH'(1) &&
				wtc_pkg::is_operator(head[0])) begin
			res.cls = wtc_pkg::CLS_OPERATOR;
		end
		res.has_punct = peel && wtc_pkg::is_set_punct(last_char);
		res.punct = last_char;
	end

endmodule

// File: hdl/wtc_result_reg.sv
// ---------------------------------------------------------------------------
// wtc_result_reg
// Result register that presents the word item and then any punctuation item.
// ---------------------------------------------------------------------------
module wtc_result_reg #(
	parameter int LINE_COUNT_WIDTH = 16,
	parameter int LENGTH_WIDTH     = 8,
	parameter int DATA_W           = 40
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  wtc_pkg::wtc_result_t        res,
	input  logic [LENGTH_WIDTH-1:0]     word_len,
	input  logic [LINE_COUNT_WIDTH-1:0] line,
	output logic                        free,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [DATA_W-1:0]           m_tdata,
	output logic                        m_tlast
);

	wtc_pkg::wtc_result_t        res_q;
	logic [LENGTH_WIDTH-1:0]     word_len_q;
	logic [LINE_COUNT_WIDTH-1:0] line_q;
	logic                        valid_q;
	logic                        second_q;
	logic                        final_item;

	wtc_pkg::wtc_class_t         cls_out;
	logic [wtc_pkg::KWI_W-1:0]   kwi_out;
	logic [LENGTH_WIDTH-1:0]     len_out;
	logic [wtc_pkg::CHAR_W-1:0]  pc_out;

	assign final_item = second_q || !res_q.has_punct;
	assign free = !valid_q || (m_tready && final_item);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			valid_q  <= 1'b1;
			second_q <= 1'b0;
		end else if (valid_q && m_tready) begin
			if (final_item) begin
				valid_q  <= 1'b0;
				second_q <= 1'b0;
			end else begin
				second_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q      <= res;
			word_len_q <= word_len;
			line_q     <= line;
		end
	end

	always_comb begin
		if (second_q) begin
			cls_out = wtc_pkg::CLS_PUNCT;
			kwi_out = '0;
			len_out = LENGTH_WIDTH'(1);
			pc_out  = res_q.punct;
		end else begin
			cls_out = res_q.cls;
			kwi_out = res_q.kwi;
			len_out = word_len_q;
			pc_out  = '0;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tlast  = final_item;
	assign m_tdata  = DATA_W'({line_q, pc_out, len_out, kwi_out, cls_out});

endmodule

// File: hdl/wtc_checker.sv
// ---------------------------------------------------------------------------
// wtc_checker
// Port-level checks on the token classifier, bound to its top level.
// ---------------------------------------------------------------------------
module wtc_checker #(
	parameter int LINE_COUNT_WIDTH = 16,
	parameter int LENGTH_WIDTH     = 8,
	parameter int DATA_W           = 40
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata,
	input logic              m_tlast
);

	localparam int LEN_LO  = wtc_pkg::CLASS_W + wtc_pkg::KWI_W;
	localparam int LINE_LO = LEN_LO + LENGTH_WIDTH + wtc_pkg::CHAR_W;

	logic [wtc_pkg::CLASS_W-1:0] cls;
	logic [LENGTH_WIDTH-1:0]     len;
	logic [LINE_COUNT_WIDTH-1:0] line;

	assign cls  = m_tdata[wtc_pkg::CLASS_W-1:0];
	assign len  = m_tdata[LEN_LO +: LENGTH_WIDTH];
	assign line = m_tdata[LINE_LO +: LINE_COUNT_WIDTH];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result item changed while stalled");

	a_punct_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && cls == wtc_pkg::CLS_PUNCT |-> m_tlast && len == LENGTH_WIDTH'(1))
		else $error("punctuation item malformed");

	a_punct_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && cls == wtc_pkg::CLS_PUNCT)
		else $error("punctuation item missing after word item");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> line != '0)
		else $error("line number is zero");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");

endmodule

bind whitespace_token_classifier wtc_checker #(
	.LINE_COUNT_WIDTH(LINE_COUNT_WIDTH),
	.LENGTH_WIDTH    (LENGTH_WIDTH),
	.DATA_W          (DATA_W)
) u_wtc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
